// ===== hw/rtl/spq_pkg.sv =====
// Shared types, constants and helpers for the sorted priority queue.
package spq_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_BITS  = 32;
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int PORT_KEY_BITS = 32;
    localparam int OCC_BITS  = 5;
    localparam int TDATA_OUT_BITS = ((PORT_KEY_BITS + OCC_BITS + 7) / 8) * 8;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic signed [KEY_BITS-1:0] key_t;
    typedef logic [CNT_BITS-1:0] cnt_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        logic push;
        logic pop;
        key_t key;
    } cell_ctrl_t;

    typedef struct packed {
        logic [PORT_KEY_BITS-1:0] key_out;
        status_t                  status;
        logic [OCC_BITS-1:0]      occupancy;
    } result_t;

    // Port key to stored key: truncate or sign-extend.
    function automatic key_t to_key(logic [PORT_KEY_BITS-1:0] raw);
        return key_t'($signed(raw));
    endfunction

    // Stored key to port key: sign-extend or truncate.
    function automatic logic [PORT_KEY_BITS-1:0] from_key(key_t k);
        return PORT_KEY_BITS'(k);
    endfunction

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One cell of the sorted chain: holds one key, descending order along the chain.
module spq_cell (
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  spq_pkg::key_t       left_key,
    input  logic                left_keeps,
    input  spq_pkg::key_t       right_key,
    output spq_pkg::key_t       key,
    output logic                keeps
);

    spq_pkg::key_t key_reg;
    spq_pkg::key_t key_next;

    // Keep on push when stored key >= new key (new key lands behind equals).
    assign keeps = occupied && (key_reg >= ctrl.key);
    assign key   = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.push)
        begin
            if (!keeps)
            begin
                key_next = left_keeps ? ctrl.key : left_key;
            end
        end
        else if (ctrl.pop)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== hw/rtl/spq_out_buf.sv =====
// Two-entry output buffer: main register plus skid register.
module spq_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  spq_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output spq_pkg::result_t out_data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    spq_pkg::result_t main_data_reg, main_data_next;
    spq_pkg::result_t skid_data_reg, skid_data_next;
    logic             take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign take      = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                main_valid_next = 1'b1;
                skid_valid_next = in_valid;
                skid_data_next  = in_data;
            end
            else
            begin
                main_data_next  = in_data;
                main_valid_next = in_valid;
            end
        end
        else if (in_valid && in_ready)
        begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain, count and result path.
//
//  channel  dir  signals                          contents
//  s_*      in   tvalid tready tdata[31:0] tuser  key_in ; op
//  m_*      out  tvalid tready tdata[39:0] tuser  key_out, occupancy ; status
//
// One beat per cycle while s_tready is high: every push or pop is done in
// the cycle it is accepted, since every cell compares the new key and
// shifts in the same edge. The result is registered in the output buffer.
// Reset clears the key count and the output buffer; cell contents stay
// undefined until written. A two-entry output buffer keeps s_tready high
// while one result waits; s_tready drops only when both entries are full.
module sorted_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key_in
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [spq_pkg::TDATA_OUT_BITS-1:0] m_tdata, // [31:0] key_out, [36:32] occupancy
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int N = spq_pkg::CAPACITY;

    spq_pkg::cnt_t       count_reg, count_next;
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::result_t    result;
    spq_pkg::result_t    out_data;
    spq_pkg::key_t       cell_key   [N];
    logic                cell_keeps [N];
    logic                cell_occ   [N];
    logic                s_fire;
    logic                full;
    logic                empty;

    assign s_fire = s_tvalid && s_tready;
    assign full   = (count_reg == spq_pkg::cnt_t'(N));
    assign empty  = (count_reg == '0);

    // Refused operations leave the chain alone.
    assign ctrl.push = s_fire && (s_tuser == spq_pkg::OP_PUSH) && !full;
    assign ctrl.pop  = s_fire && (s_tuser == spq_pkg::OP_POP) && !empty;
    assign ctrl.key  = spq_pkg::to_key(s_tdata);

    // Cell 0 holds the largest key; ties keep arrival order along the chain.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        spq_pkg::key_t left_key;
        spq_pkg::key_t right_key;
        logic          left_keeps;

        assign cell_occ[i] = (count_reg > spq_pkg::cnt_t'(i));

        if (i == 0)
        begin : g_head
            assign left_key   = ctrl.key;
            assign left_keeps = 1'b1;
        end
        else
        begin : g_body
            assign left_key   = cell_key[i-1];
            assign left_keeps = cell_keeps[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign right_key = cell_key[i];
        end
        else
        begin : g_mid
            assign right_key = cell_key[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (cell_occ[i]),
            .left_key   (left_key),
            .left_keeps (left_keeps),
            .right_key  (right_key),
            .key        (cell_key[i]),
            .keeps      (cell_keeps[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Result for the beat accepted this cycle.
    always_comb
    begin
        result.key_out   = '0;
        result.status    = spq_pkg::ST_OK;
        result.occupancy = spq_pkg::OCC_BITS'(count_next);
        if (s_tuser == spq_pkg::OP_PUSH)
        begin
            if (full)
            begin
                result.status = spq_pkg::ST_FULL;
            end
        end
        else
        begin
            if (empty)
            begin
                result.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                result.key_out = spq_pkg::from_key(cell_key[0]);
            end
        end
    end

    spq_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_fire),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = spq_pkg::TDATA_OUT_BITS'({out_data.occupancy, out_data.key_out});
    assign m_tuser = out_data.status;

    // Count never goes past the chain length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::cnt_t'(N))
        else $error("key count above capacity");

    // Back-pressure only when a result is held at the output.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // An accepted push into a non-full chain grows the count by one.
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow count");

    // A successful pop drops the count by one.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not shrink count");

endmodule
